// ===== hdl/sync_word_frame_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Sync word frame parser assertion macros
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_FRAME_PARSER_ASSERT_SVH
`define SYNC_WORD_FRAME_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SWFP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("swfp assertion failed");
// Condition must never be true outside reset.
`define SWFP_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("swfp forbidden condition seen");
`else
`define SWFP_ASSERT(label, clk, rst_n, prop)
`define SWFP_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hdl/swfp_pkg.sv =====
// ----------------------------------------------------------------------------
// swfp_pkg
// Shared types and constants of the sync word frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swfp_pkg;

    localparam int RESULT_CAP = 64;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 2;

    // report kinds
    localparam logic [1:0] KIND_CONTROL = 2'd0;
    localparam logic [1:0] KIND_INIT    = 2'd1;
    localparam logic [1:0] KIND_REPEAT  = 2'd2;
    localparam logic [1:0] KIND_EXPIRY  = 2'd3;

    // message type bytes
    localparam logic [7:0] TYPE_CONTROL = 8'h01;
    localparam logic [7:0] TYPE_INIT    = 8'h02;

    // request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT = 3'd4;

    // register reset values ("STAR")
    localparam logic [31:0] RST_HEADER     = 32'h5354_4152;
    localparam logic [6:0]  RST_CONTROL    = 7'd36;
    localparam logic [6:0]  RST_INIT       = 7'd16;
    localparam logic [15:0] RST_TIMEOUT    = 16'd100;
    localparam logic [15:0] RST_DISCONNECT = 16'd1000;

    typedef struct packed {
        logic [31:0] header_word;
        logic [6:0]  control_len;
        logic [6:0]  init_len;
        logic [15:0] frame_timeout_ticks;
        logic [15:0] disconnect_ticks;
    } cfg_t;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

endpackage

// ===== hdl/swfp_in_if.sv =====
// ----------------------------------------------------------------------------
// swfp_in_if
// Input channel: received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swfp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== hdl/swfp_out_if.sv =====
// ----------------------------------------------------------------------------
// swfp_out_if
// Result channel: payload bytes and link reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swfp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] report_kind;
    logic [7:0] out_byte;
    logic [5:0] byte_index;
    logic       last_flag;

    modport source (output valid, output report_kind, output out_byte,
                    output byte_index, output last_flag, input ready);
    modport sink   (input valid, input report_kind, input out_byte,
                    input byte_index, input last_flag, output ready);
endinterface

// ===== hdl/swfp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// swfp_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hdl/sync_word_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_word_frame_parser
// Sync word framed packet parser with idle timeout and link watchdog.
// ----------------------------------------------------------------------------
// Bytes and millisecond ticks enter on rx, which takes a transfer whenever the
// front end is not held. Results leave on report: a payload frame of N bytes
// pops its command, then is replayed from the payload store, each byte read
// from the RAM into the output register and held there until report takes it;
// repeated init and watchdog reports skip the store and are sent as one result.
// A two-entry command queue separates the front end from the back end, so
// hunting, type decode and ticks go on while a frame drains. Once the front end
// has entered a payload, every rx transfer, ticks included, waits until the
// drain is done, since the next payload byte would overwrite the store; rx also
// holds while the queue is full. Registers must be written on cfg only while the
// block is idle; the block does not enforce this. Writes act once registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_word_frame_parser_assert.svh"

module sync_word_frame_parser #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    swfp_in_if.sink    rx,
    swfp_out_if.source report,
    swfp_cfg_if.sink   cfg
);

    localparam int LEN_CAP = (MAX_PAYLOAD < swfp_pkg::RESULT_CAP) ?
                             MAX_PAYLOAD : swfp_pkg::RESULT_CAP;
    localparam int AW      = $clog2(LEN_CAP);

    // Register file
    swfp_pkg::cfg_t cfg_reg, cfg_next;

    // Front end to queue and store
    swfp_pkg::q_wr_t q_wr;
    swfp_pkg::cmd_t  q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            back_active;
    logic            back_busy;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    logic [7:0]      ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [7:0]      ram_rd_data;

    // Register writes are always taken; unknown indexes drop the transfer.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                swfp_pkg::CFG_HEADER:     cfg_next.header_word         = cfg.wdata;
                swfp_pkg::CFG_CONTROL:    cfg_next.control_len         = cfg.wdata[6:0];
                swfp_pkg::CFG_INIT:       cfg_next.init_len            = cfg.wdata[6:0];
                swfp_pkg::CFG_TIMEOUT:    cfg_next.frame_timeout_ticks = cfg.wdata[15:0];
                swfp_pkg::CFG_DISCONNECT: cfg_next.disconnect_ticks    = cfg.wdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word         <= swfp_pkg::RST_HEADER;
            cfg_reg.control_len         <= swfp_pkg::RST_CONTROL;
            cfg_reg.init_len            <= swfp_pkg::RST_INIT;
            cfg_reg.frame_timeout_ticks <= swfp_pkg::RST_TIMEOUT;
            cfg_reg.disconnect_ticks    <= swfp_pkg::RST_DISCONNECT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The store is busy from the moment a command is queued until its last
    // result transfers.
    assign back_busy = !q_empty || back_active;

    swfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .back_busy (back_busy),
        .q_wr      (q_wr),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data)
    );

    swfp_ram #(
        .WIDTH (8),
        .DEPTH (LEN_CAP)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    swfp_cmd_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    swfp_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .active  (back_active),
        .report  (report)
    );

    `SWFP_NEVER(a_no_queue_overflow, clk, rst_n, q_wr.push && q_full && !q_pop)
    `SWFP_NEVER(a_no_store_overwrite, clk, rst_n, ram_wr_en && back_busy)
    `SWFP_ASSERT(a_pop_has_entry, clk, rst_n, q_pop |-> !q_empty)

endmodule

// ===== hdl/swfp_ram.sv =====
// ----------------------------------------------------------------------------
// swfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/swfp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// swfp_cmd_fifo
// Short command queue between the parser front end and the report back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swfp_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  swfp_pkg::q_wr_t     wr,
    input  logic                pop,
    output swfp_pkg::cmd_t      head,
    output logic                full,
    output logic                empty
);

    localparam int PW = $clog2(swfp_pkg::QDEPTH);
    localparam int CW = $clog2(swfp_pkg::QDEPTH + 1);

    swfp_pkg::cmd_t entry_reg [swfp_pkg::QDEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(swfp_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr.push)
        begin
            wptr_next = (wptr_reg == PW'(swfp_pkg::QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(swfp_pkg::QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (wr.push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !wr.push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            entry_reg[wptr_reg] <= wr.cmd;
        end
    end

endmodule

// ===== hdl/swfp_front.sv =====
// ----------------------------------------------------------------------------
// swfp_front
// Parser front end: sync hunt, type decode, payload store, idle tick timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swfp_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    swfp_in_if.sink                            rx,
    input  swfp_pkg::cfg_t                     cfg,
    input  logic                               q_full,
    input  logic                               back_busy,
    output swfp_pkg::q_wr_t                    q_wr,
    output logic                               wr_en,
    output logic [$clog2((MAX_PAYLOAD < swfp_pkg::RESULT_CAP) ?
                         MAX_PAYLOAD : swfp_pkg::RESULT_CAP)-1:0] wr_addr,
    output logic [7:0]                         wr_data
);

    localparam int LEN_CAP = (MAX_PAYLOAD < swfp_pkg::RESULT_CAP) ?
                             MAX_PAYLOAD : swfp_pkg::RESULT_CAP;
    localparam int AW      = $clog2(LEN_CAP);
    localparam logic [swfp_pkg::LEN_W-1:0] CAP_V = swfp_pkg::LEN_W'(LEN_CAP);
    localparam logic [2:0]  SYNC_FULL = 3'd4;
    localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_TYPE    = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [31:0]                win_reg, win_next;
    logic [2:0]                 sync_reg, sync_next;
    logic                       init_reg, init_next;
    logic [swfp_pkg::LEN_W-1:0] cnt_reg, cnt_next;
    logic [15:0]                idle_reg, idle_next;
    logic                       link_reg, link_next;

    logic                       accept;
    logic [swfp_pkg::LEN_W-1:0] len_sel;
    logic [swfp_pkg::LEN_W-1:0] eff_len;
    logic [swfp_pkg::LEN_W-1:0] cnt_inc;
    logic [15:0]                idle_inc;
    logic [2:0]                 sync_inc;
    logic [31:0]                win_shift;

    // stall all transfers while the queue is full, and in the payload phase while the back end may still read the store
    assign rx.ready = !q_full && !((phase_reg == PH_PAYLOAD) && back_busy);
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        len_sel = init_reg ? cfg.init_len : cfg.control_len;
        if (len_sel == '0)
        begin
            eff_len = swfp_pkg::LEN_W'(1);
        end
        else if (len_sel > CAP_V)
        begin
            eff_len = CAP_V;
        end
        else
        begin
            eff_len = len_sel;
        end
    end

    assign cnt_inc   = cnt_reg + 1'b1;
    assign idle_inc  = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
    assign sync_inc  = (sync_reg == SYNC_FULL) ? sync_reg : sync_reg + 3'd1;
    assign win_shift = {win_reg[23:0], rx.rx_byte};

    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = rx.rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        win_next   = win_reg;
        sync_next  = sync_reg;
        init_next  = init_reg;
        cnt_next   = cnt_reg;
        idle_next  = idle_reg;
        link_next  = link_reg;
        q_wr       = '0;
        wr_en      = 1'b0;

        if (accept && (rx.req_type == swfp_pkg::REQ_TICK))
        begin
            idle_next = idle_inc;
            if (idle_inc > cfg.frame_timeout_ticks)
            begin
                phase_next = PH_HUNT;
                sync_next  = '0;
                cnt_next   = '0;
            end
            if (link_reg && (idle_inc > cfg.disconnect_ticks))
            begin
                phase_next  = PH_HUNT;
                win_next    = '0;
                sync_next   = '0;
                init_next   = 1'b0;
                cnt_next    = '0;
                idle_next   = '0;
                link_next   = 1'b0;
                q_wr.push     = 1'b1;
                q_wr.cmd.kind = swfp_pkg::KIND_EXPIRY;
                q_wr.cmd.len  = swfp_pkg::LEN_W'(1);
            end
        end
        else if (accept)
        begin
            idle_next = '0;
            unique case (phase_reg)
                PH_TYPE:
                begin
                    if ((rx.rx_byte == swfp_pkg::TYPE_CONTROL) ||
                        (rx.rx_byte == swfp_pkg::TYPE_INIT))
                    begin
                        init_next  = (rx.rx_byte == swfp_pkg::TYPE_INIT);
                        cnt_next   = '0;
                        phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        sync_next  = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr_en = 1'b1;
                    if (cnt_inc >= eff_len)
                    begin
                        phase_next = PH_HUNT;
                        sync_next  = '0;
                        cnt_next   = '0;
                        q_wr.push  = 1'b1;
                        if (init_reg && link_reg)
                        begin
                            // repeated init: full restart
                            win_next      = '0;
                            init_next     = 1'b0;
                            link_next     = 1'b0;
                            q_wr.cmd.kind = swfp_pkg::KIND_REPEAT;
                            q_wr.cmd.len  = swfp_pkg::LEN_W'(1);
                        end
                        else
                        begin
                            link_next     = link_reg | init_reg;
                            q_wr.cmd.kind = init_reg ? swfp_pkg::KIND_INIT
                                                     : swfp_pkg::KIND_CONTROL;
                            q_wr.cmd.len  = cnt_inc;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    win_next   = win_shift;
                    sync_next  = sync_inc;
                    if ((sync_inc == SYNC_FULL) && (win_shift == cfg.header_word))
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            win_reg   <= '0;
            sync_reg  <= '0;
            init_reg  <= 1'b0;
            cnt_reg   <= '0;
            idle_reg  <= '0;
            link_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            win_reg   <= win_next;
            sync_reg  <= sync_next;
            init_reg  <= init_next;
            cnt_reg   <= cnt_next;
            idle_reg  <= idle_next;
            link_reg  <= link_next;
        end
    end

endmodule

// ===== hdl/swfp_back.sv =====
// ----------------------------------------------------------------------------
// swfp_back
// Report back end: drains queued commands, reads the payload store, drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_word_frame_parser_assert.svh"

module swfp_back #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swfp_pkg::cmd_t                     head,
    input  logic                               q_empty,
    output logic                               pop,
    output logic                               rd_en,
    output logic [$clog2((MAX_PAYLOAD < swfp_pkg::RESULT_CAP) ?
                         MAX_PAYLOAD : swfp_pkg::RESULT_CAP)-1:0] rd_addr,
    input  logic [7:0]                         rd_data,
    output logic                               active,
    swfp_out_if.source                         report
);

    localparam int LEN_CAP = (MAX_PAYLOAD < swfp_pkg::RESULT_CAP) ?
                             MAX_PAYLOAD : swfp_pkg::RESULT_CAP;
    localparam int AW      = $clog2(LEN_CAP);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_SEND  = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [swfp_pkg::LEN_W-1:0] len_reg, len_next;
    logic [swfp_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [7:0]                 byte_reg, byte_next;
    logic [swfp_pkg::IDX_W-1:0] oidx_reg, oidx_next;
    logic                       last_reg, last_next;

    assign active             = (state_reg != S_IDLE);
    assign report.valid       = (state_reg == S_SEND);
    assign report.report_kind = kind_reg;
    assign report.out_byte    = byte_reg;
    assign report.byte_index  = oidx_reg;
    assign report.last_flag   = last_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        oidx_next  = oidx_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    kind_next = head.kind;
                    len_next  = head.len;
                    idx_next  = '0;
                    if ((head.kind == swfp_pkg::KIND_REPEAT) ||
                        (head.kind == swfp_pkg::KIND_EXPIRY))
                    begin
                        byte_next  = '0;
                        oidx_next  = '0;
                        last_next  = 1'b1;
                        state_next = S_SEND;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                byte_next  = rd_data;
                oidx_next  = idx_reg;
                last_next  = (({1'b0, idx_reg} + 7'd1) == len_reg);
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (report.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance to the next stored byte
                        idx_next   = idx_reg + 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = idx_next[AW-1:0];
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        oidx_reg <= oidx_next;
        last_reg <= last_next;
    end

    `SWFP_ASSERT(a_fetch_follows_read, clk, rst_n, (state_reg == S_FETCH) |-> $past(rd_en))
    `SWFP_ASSERT(a_report_fields, clk, rst_n, ((state_reg == S_SEND) && kind_reg[1]) |-> ((byte_reg == 8'd0) && (oidx_reg == '0) && last_reg))
    `SWFP_ASSERT(a_burst_in_range, clk, rst_n, ((state_reg == S_SEND) && !last_reg) |-> (({1'b0, oidx_reg} + 7'd1) < len_reg))

endmodule
